// ----- rtl/pbd_pkg.sv -----
// pbd_pkg: shared types and constants of the packbits line decoder
// token passed from the front classifier to the back line tracker, queue status
// no dependencies
package pbd_pkg;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 13;
	localparam int LINE_CFG_W = 13;

	localparam logic [CFG_IDX_W-1:0] REG_COMPRESSED = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_LINE_BYTES = CFG_IDX_W'(1);

	localparam logic [LINE_CFG_W-1:0] LINE_BYTES_RESET = LINE_CFG_W'(320);

	localparam logic [7:0] HDR_NOOP = 8'h80;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef logic [2:0] tok_kind_t;

	localparam tok_kind_t TK_PASS = 3'd0; // byte passed through, compression off
	localparam tok_kind_t TK_RUN  = 3'd1; // literal or repeat header, count = run length
	localparam tok_kind_t TK_NOOP = 3'd2; // no-op header
	localparam tok_kind_t TK_LIT  = 3'd3; // literal data byte
	localparam tok_kind_t TK_REP  = 3'd4; // repeat value, count = repeat count

	typedef struct packed {
		tok_kind_t  kind;
		logic [7:0] value;
		logic [7:0] count;
		logic       last;
	} token_t;

	typedef struct packed {
		logic              full;
		logic              empty;
		logic [QCNT_W-1:0] count;
	} queue_stat_t;

endpackage

// ----- rtl/pbd_in_if.sv -----
// pbd_in_if: encoded byte channel, valid/ready with one byte per beat
// no dependencies
interface pbd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source(output valid, output in_byte, input ready);
	modport sink(input valid, input in_byte, output ready);
endinterface

// ----- rtl/pbd_out_if.sv -----
// pbd_out_if: decoded result channel, valid/ready with one result per beat
// no dependencies
interface pbd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_value;
	logic [7:0] repeat_count;
	logic       end_of_line;
	logic       overrun;

	modport source(output valid, output out_value, output repeat_count,
		output end_of_line, output overrun, input ready);
	modport sink(input valid, input out_value, input repeat_count,
		input end_of_line, input overrun, output ready);
endinterface

// ----- rtl/pbd_cfg_if.sv -----
// pbd_cfg_if: register write channel, valid/ready with index and data
// depends on pbd_pkg for field widths
interface pbd_cfg_if
	import pbd_pkg::*;
;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// ----- rtl/pbd_front.sv -----
// pbd_front: accepts encoded bytes, tracks the run phase and classifies each byte
// depends on pbd_pkg and pbd_in_if
module pbd_front
	import pbd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	pbd_in_if.sink     enc,
	input  logic       compressed,
	input  logic       full,
	output logic       push,
	output token_t     tok
);

	localparam logic [1:0] PH_HEADER  = 2'd0;
	localparam logic [1:0] PH_LITERAL = 2'd1;
	localparam logic [1:0] PH_REPEAT  = 2'd2;

	logic [1:0] phase_q, phase_n;
	logic [7:0] lit_left_q, lit_left_n;
	logic [7:0] b;
	logic [7:0] lit_dec;

	assign b        = enc.in_byte;
	assign enc.ready = !full;
	assign push     = enc.valid && !full;
	assign lit_dec  = (lit_left_q != 8'd0) ? lit_left_q - 8'd1 : lit_left_q;

	always_comb begin
		phase_n    = phase_q;
		lit_left_n = lit_left_q;
		tok.kind   = TK_NOOP;
		tok.value  = b;
		tok.count  = 8'd1;
		tok.last   = 1'b0;
		if (!compressed) begin
			// pass-through drops any pending run
			tok.kind   = TK_PASS;
			phase_n    = PH_HEADER;
			lit_left_n = 8'd0;
		end else begin
			unique case (phase_q)
				PH_LITERAL: begin
					tok.kind   = TK_LIT;
					tok.last   = (lit_dec == 8'd0);
					lit_left_n = lit_dec;
					if (lit_dec == 8'd0) begin
						phase_n = PH_HEADER;
					end
				end
				PH_REPEAT: begin
					tok.kind   = TK_REP;
					tok.count  = lit_left_q;
					phase_n    = PH_HEADER;
					lit_left_n = 8'd0;
				end
				default: begin
					phase_n = PH_HEADER;
					if (!b[7]) begin
						tok.kind   = TK_RUN;
						tok.count  = b + 8'd1;
						lit_left_n = b + 8'd1;
						phase_n    = PH_LITERAL;
					end else if (b != HDR_NOOP) begin
						// 1 - h for a negative header h
						tok.kind   = TK_RUN;
						tok.count  = 8'(9'd257 - {1'b0, b});
						lit_left_n = 8'(9'd257 - {1'b0, b});
						phase_n    = PH_REPEAT;
					end else begin
						tok.kind = TK_NOOP;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			lit_left_q <= 8'd0;
		end else if (push) begin
			phase_q    <= phase_n;
			lit_left_q <= lit_left_n;
		end
	end

endmodule

// ----- rtl/pbd_queue.sv -----
// pbd_queue: short token queue between the front classifier and the back stage
// depends on pbd_pkg
module pbd_queue
	import pbd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  token_t      push_tok,
	input  logic        pop,
	output token_t      head,
	output queue_stat_t stat
);

	token_t            slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign head       = slot_q[rd_ptr_q];
	assign stat.count = count_q;
	assign stat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

// ----- rtl/pbd_back.sv -----
// pbd_back: carries out tokens against the scan line and drives the result register
// depends on pbd_pkg and pbd_out_if
module pbd_back
	import pbd_pkg::*;
#(
	parameter int MAX_LINE_BYTES = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [LINE_CFG_W-1:0] line_bytes,
	input  token_t                head,
	input  logic                  head_valid,
	output logic                  pop,
	pbd_out_if.source             dec
);

	localparam int LW = $clog2(MAX_LINE_BYTES + 1);

	logic [LW-1:0] line_left_q, line_left_n;
	logic          run_over_q, run_over_n;
	logic [LW-1:0] reload_len;
	logic [LW-1:0] base;
	logic          produces;
	logic          can_load;
	logic          res_eol;
	logic          res_ovr;
	logic [7:0]    res_cnt;

	logic          out_valid_q;
	logic [7:0]    out_value_q;
	logic [7:0]    out_count_q;
	logic          out_eol_q;
	logic          out_ovr_q;

	// line length clamped to 1..MAX_LINE_BYTES
	always_comb begin
		if (line_bytes == '0) begin
			reload_len = LW'(1);
		end else if (32'(line_bytes) > MAX_LINE_BYTES) begin
			reload_len = LW'(MAX_LINE_BYTES);
		end else begin
			reload_len = LW'(line_bytes);
		end
	end

	assign base     = (line_left_q == '0) ? reload_len : line_left_q;
	assign produces = (head.kind == TK_PASS) || (head.kind == TK_LIT) || (head.kind == TK_REP);
	assign can_load = !out_valid_q || dec.ready;
	assign pop      = head_valid && (!produces || can_load);

	always_comb begin
		line_left_n = line_left_q;
		run_over_n  = run_over_q;
		res_eol     = 1'b0;
		res_ovr     = 1'b0;
		res_cnt     = 8'd1;
		unique case (head.kind)
			TK_PASS: begin
				line_left_n = base - LW'(1);
				run_over_n  = 1'b0;
				res_eol     = (base == LW'(1));
			end
			TK_RUN: begin
				if (32'(head.count) > 32'(base)) begin
					run_over_n  = 1'b1;
					line_left_n = '0;
				end else begin
					run_over_n  = 1'b0;
					line_left_n = base - LW'(head.count);
				end
			end
			TK_NOOP: begin
				line_left_n = base;
			end
			TK_LIT: begin
				res_eol = head.last && (line_left_q == '0);
				res_ovr = run_over_q;
			end
			TK_REP: begin
				res_cnt = head.count;
				res_eol = (line_left_q == '0);
				res_ovr = run_over_q;
			end
			default: begin
				line_left_n = line_left_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_left_q <= '0;
			run_over_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				line_left_q <= line_left_n;
				run_over_q  <= run_over_n;
			end
			if (pop && produces) begin
				out_valid_q <= 1'b1;
			end else if (dec.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && produces) begin
			out_value_q <= head.value;
			out_count_q <= res_cnt;
			out_eol_q   <= res_eol;
			out_ovr_q   <= res_ovr;
		end
	end

	assign dec.valid        = out_valid_q;
	assign dec.out_value    = out_value_q;
	assign dec.repeat_count = out_count_q;
	assign dec.end_of_line  = out_eol_q;
	assign dec.overrun      = out_ovr_q;

endmodule

// ----- rtl/packbits_line_decoder_top.sv -----
// packbits_line_decoder_top: top level of the packbits scan line decoder
// depends on pbd_pkg, the channel interfaces, pbd_front, pbd_queue and pbd_back
//
// Decodes a ByteRun1 byte stream into scan lines. One encoded byte is taken per
// cycle on enc unless the queue is full; headers give no beat on dec, every
// literal or passed byte gives one beat with repeat_count 1, and a repeat run
// gives one beat carrying the value and its count. The front classifies a byte
// against the run phase in its accept cycle and writes it to the token queue;
// the back accounts it against the line and loads the dec output register.
// Sustained rate is one byte per cycle unless dec stalls, set by the front phase
// register and the back line counter, each of which updates once per byte. A
// four-entry token queue lets the front keep taking bytes while dec is stalled;
// enc drops ready only once that queue fills. Registers are written through cfg,
// which is always ready, and must be written only while the block is idle.
module packbits_line_decoder_top
	import pbd_pkg::*;
#(
	parameter int MAX_LINE_BYTES = 4096
) (
	input  logic       clk,
	input  logic       arst_n,
	pbd_in_if.sink     enc,
	pbd_out_if.source  dec,
	pbd_cfg_if.sink    cfg
);

	// configuration registers
	logic                  compressed_q;
	logic [LINE_CFG_W-1:0] line_bytes_q;

	// front to queue
	logic        push;
	token_t      push_tok;

	// queue to back
	logic        pop;
	token_t      head;
	queue_stat_t q_stat;

	assign cfg.ready = 1'b1;

	// register writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			compressed_q <= 1'b1;
			line_bytes_q <= LINE_BYTES_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_COMPRESSED: compressed_q <= cfg.data[0];
				REG_LINE_BYTES: line_bytes_q <= cfg.data[LINE_CFG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// front: accept and classify each byte by run phase
	pbd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.enc        (enc),
		.compressed (compressed_q),
		.full       (q_stat.full),
		.push       (push),
		.tok        (push_tok)
	);

	// token queue decouples the two sides
	pbd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_tok (push_tok),
		.pop      (pop),
		.head     (head),
		.stat     (q_stat)
	);

	// back: line accounting, end of line and overrun, result register
	pbd_back #(
		.MAX_LINE_BYTES (MAX_LINE_BYTES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.line_bytes (line_bytes_q),
		.head       (head),
		.head_valid (!q_stat.empty),
		.pop        (pop),
		.dec        (dec)
	);

`ifndef ASSERT_OFF
	// queue never holds more tokens than it has slots
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.count <= QCNT_W'(QUEUE_DEPTH))
		else $error("token queue over its depth");

	// a push without a pop grows the queue by exactly one
	a_queue_grow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> q_stat.count == $past(q_stat.count) + QCNT_W'(1))
		else $error("token queue count lost a push");

	// a result beat cannot appear without a pending token
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.empty && !dec.valid |=> !dec.valid)
		else $error("result beat with no token behind it");

	// every result carries a count of at least one
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		dec.valid |-> dec.repeat_count != 8'd0)
		else $error("result beat with zero repeat count");
`endif

endmodule

// ----- bench/testbench.sv -----
// testbench: self-checking bench for packbits_line_decoder_top
// directed table then random runs, each dec beat checked vs table or in-bench decoder
// depends on pbd_pkg, pbd_in_if, pbd_out_if, pbd_cfg_if and the rtl top
module testbench
	import pbd_pkg::*;
;

	localparam int MAX_LINE     = 4096;
	// registered byte path plus the four-entry token queue, with margin
	localparam int DRAIN_CYCLES = 10;
	localparam int RAND_PHASES  = 8;

	// index past the register list, the block must ignore it
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = '1;

	// one decoded beat as seen on dec
	typedef struct packed {
		logic [7:0] value;
		logic [7:0] count;
		logic       eol;
		logic       ovr;
	} beat_t;

	// decoder phase of the in-bench copy
	typedef enum logic [1:0] {
		HUNT_HEADER,
		IN_LITERAL,
		AWAIT_VALUE
	} run_mode_e;

	typedef enum logic {
		STEP_BYTE,
		STEP_REG
	} step_kind_e;

	// one row of the directed table
	typedef struct packed {
		step_kind_e             kind;
		logic [7:0]             enc_byte;
		logic [CFG_IDX_W-1:0]   idx;
		logic [CFG_DATA_W-1:0]  data;
		logic                   typed;
		beat_t                  want;
	} dir_step_t;

	logic clk;
	logic arst_n;

	pbd_in_if  enc();
	pbd_out_if dec();
	pbd_cfg_if cfg();

	packbits_line_decoder_top #(
		.MAX_LINE_BYTES(MAX_LINE)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.enc(enc),
		.dec(dec),
		.cfg(cfg)
	);

	// register copies
	logic                  cfg_compressed;
	logic [CFG_DATA_W-1:0] cfg_line_bytes;

	// decoder state copies
	run_mode_e mode;
	int        run_left;
	int        line_room;
	logic      run_flagged;

	beat_t pending_beats[$];
	int    errors;
	int    beats_seen;

	// idle controls for both sides
	bit send_gaps;
	bit sink_stalls;

	dir_step_t dir_steps[$];

	task automatic report(input string msg);
		$display("MISMATCH: %s", msg);
		errors++;
	endtask

	// decode one accepted byte, returns the beat it causes if any
	task automatic decode_byte(input logic [7:0] b, output logic has, output beat_t res);
		int reload;
		has = 1'b0;
		res = '0;
		// out-of-range line lengths are clamped at each reload
		reload = (cfg_line_bytes == 0) ? 1 :
			((cfg_line_bytes > MAX_LINE) ? MAX_LINE : int'(cfg_line_bytes));
		if (!cfg_compressed) begin
			// pass-through drops any open run
			mode = HUNT_HEADER;
			run_left = 0;
			run_flagged = 1'b0;
			if (line_room == 0)
				line_room = reload;
			line_room--;
			has = 1'b1;
			res = '{b, 8'd1, line_room == 0, 1'b0};
		end else begin
			case (mode)
				IN_LITERAL: begin
					if (run_left > 0)
						run_left--;
					if (run_left == 0)
						mode = HUNT_HEADER;
					has = 1'b1;
					res = '{b, 8'd1, (run_left == 0) && (line_room == 0), run_flagged};
				end
				AWAIT_VALUE: begin
					mode = HUNT_HEADER;
					has = 1'b1;
					res = '{b, 8'(run_left), line_room == 0, run_flagged};
					run_left = 0;
				end
				default: begin
					// header: no beat, reload the line even for a no-op
					mode = HUNT_HEADER;
					if (line_room == 0)
						line_room = reload;
					if (b != HDR_NOOP) begin
						run_left = b[7] ? (257 - int'(b)) : (int'(b) + 1);
						// a run past the line end is flagged and closes the line
						run_flagged = run_left > line_room;
						line_room = run_flagged ? 0 : line_room - run_left;
						mode = b[7] ? AWAIT_VALUE : IN_LITERAL;
					end
				end
			endcase
		end
	endtask

	// send one encoded byte, optionally after a gap, and book its beat
	task automatic push_byte(input logic [7:0] b, input logic typed, input beat_t want);
		logic  has;
		beat_t got;
		cfg.valid <= 1'b0;
		if (send_gaps && $urandom_range(0, 4) == 0) begin
			enc.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		enc.valid <= 1'b1;
		enc.in_byte <= b;
		do @(posedge clk); while (!enc.ready);
		decode_byte(b, has, got);
		// typed rows stand in for the decoder output
		if (typed)
			pending_beats.push_back(want);
		else if (has)
			pending_beats.push_back(got);
	endtask

	// register write, valid is left high so writes can go back to back
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= d;
		do @(posedge clk); while (!cfg.ready);
		if (idx == REG_COMPRESSED)
			cfg_compressed = d[0];
		else if (idx == REG_LINE_BYTES)
			cfg_line_bytes = d;
	endtask

	// stop sending and let the block drain, including trailing headers
	task automatic settle();
		enc.valid <= 1'b0;
		cfg.valid <= 1'b0;
		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic dir_step_t byte_step(input logic [7:0] b);
		return '{STEP_BYTE, b, '0, '0, 1'b0, '0};
	endfunction

	// out_value always equals the byte that caused the beat
	function automatic dir_step_t beat_step(input logic [7:0] b, input logic [7:0] c,
		input logic e, input logic o);
		return '{STEP_BYTE, b, '0, '0, 1'b1, '{b, c, e, o}};
	endfunction

	function automatic dir_step_t reg_step(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] d);
		return '{STEP_REG, 8'h00, idx, d, 1'b0, '0};
	endfunction

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// dec ready with random stall bursts
	initial begin
		dec.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (sink_stalls && $urandom_range(0, 2) == 0) begin
				dec.ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
			dec.ready <= 1'b1;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	end

	// checker: every dec beat against the oldest booked beat
	always @(posedge clk) begin : check_beats
		beat_t got;
		beat_t want;
		if (arst_n && dec.valid === 1'b1 && dec.ready === 1'b1) begin
			got = '{dec.out_value, dec.repeat_count, dec.end_of_line, dec.overrun};
			beats_seen++;
			if (pending_beats.size() == 0) begin
				report($sformatf("beat %0d unexpected, value %0h count %0d",
					beats_seen, got.value, got.count));
			end else begin
				want = pending_beats.pop_front();
				if (got.value !== want.value)
					report($sformatf("beat %0d out_value %0h want %0h",
						beats_seen, got.value, want.value));
				if (got.count !== want.count)
					report($sformatf("beat %0d repeat_count %0d want %0d",
						beats_seen, got.count, want.count));
				if (got.eol !== want.eol)
					report($sformatf("beat %0d end_of_line %b want %b",
						beats_seen, got.eol, want.eol));
				if (got.ovr !== want.ovr)
					report($sformatf("beat %0d overrun %b want %b",
						beats_seen, got.ovr, want.ovr));
			end
		end
	end

	// main sequence
	initial begin
		int        n;
		int        target;
		int        len;
		int        keep;
		int        ph;
		logic [CFG_DATA_W-1:0] lb;
		dir_step_t st;
		bit        prev_reg;

		errors = 0;
		beats_seen = 0;
		send_gaps = 1'b1;
		sink_stalls = 1'b1;
		enc.valid <= 1'b0;
		enc.in_byte <= 8'h00;
		cfg.valid <= 1'b0;
		cfg.index <= REG_COMPRESSED;
		cfg.data <= '0;

		// register and state copies at their reset values
		cfg_compressed = 1'b1;
		cfg_line_bytes = LINE_BYTES_RESET;
		mode = HUNT_HEADER;
		run_left = 0;
		line_room = 0;
		run_flagged = 1'b0;

		arst_n <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		dir_steps = '{
			// reset line of 320: no-op reloads, three repeats of 128 overshoot it
			byte_step(HDR_NOOP),
			byte_step(8'h81), beat_step(8'h00, 8'd128, 1'b0, 1'b0),
			byte_step(8'h81), beat_step(8'h11, 8'd128, 1'b0, 1'b0),
			byte_step(8'h81), beat_step(8'h22, 8'd128, 1'b1, 1'b1),
			// short lines of 4
			reg_step(REG_LINE_BYTES, 13'd4),
			byte_step(8'h01), beat_step(8'hFF, 8'd1, 1'b0, 1'b0),
			beat_step(8'h00, 8'd1, 1'b0, 1'b0),
			// repeat of 2 fills the line exactly
			byte_step(8'hFF), beat_step(8'hA5, 8'd2, 1'b1, 1'b0),
			byte_step(8'h00), beat_step(8'h5A, 8'd1, 1'b0, 1'b0),
			// literal of 5 against 3 left: whole run flagged
			byte_step(8'h04), byte_step(8'h10), byte_step(8'h20),
			byte_step(8'h30), byte_step(8'h40), beat_step(8'h50, 8'd1, 1'b1, 1'b1),
			// open a literal of 4 and leave it after one byte
			byte_step(8'h03), beat_step(8'hC3, 8'd1, 1'b0, 1'b0),
			// compression off mid-run, spare index ignored
			reg_step(REG_COMPRESSED, 13'd0),
			reg_step(REG_SPARE, '1),
			beat_step(8'h7F, 8'd1, 1'b0, 1'b0),
			beat_step(8'h80, 8'd1, 1'b0, 1'b0),
			beat_step(8'h81, 8'd1, 1'b0, 1'b0),
			beat_step(8'h00, 8'd1, 1'b1, 1'b0)
		};

		prev_reg = 1'b1;
		foreach (dir_steps[i]) begin
			st = dir_steps[i];
			if (st.kind == STEP_REG) begin
				if (!prev_reg)
					settle();
				write_reg(st.idx, st.data);
				prev_reg = 1'b1;
			end else begin
				push_byte(st.enc_byte, st.typed, st.want);
				prev_reg = 1'b0;
			end
		end

		// random phases: new settings, then mostly well-formed runs
		for (ph = 0; ph < RAND_PHASES; ph++) begin
			settle();
			if (ph == RAND_PHASES - 1) begin
				// last phase runs at full rate
				send_gaps = 1'b0;
				sink_stalls = 1'b0;
			end else begin
				send_gaps = ($urandom_range(0, 3) != 0);
				sink_stalls = ($urandom_range(0, 3) != 0);
			end
			if ($urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 7))
					0: lb = '0;
					1: lb = CFG_DATA_W'(MAX_LINE);
					2: lb = '1;
					3: lb = CFG_DATA_W'($urandom_range(1, 4));
					4: lb = CFG_DATA_W'($urandom_range(MAX_LINE + 1, 8190));
					default: lb = CFG_DATA_W'($urandom_range(1, 48));
				endcase
				write_reg(REG_LINE_BYTES, lb);
			end
			if ($urandom_range(0, 1) == 0)
				// only bit 0 counts, upper bits random
				write_reg(REG_COMPRESSED,
					{(CFG_DATA_W - 1)'($urandom), 1'($urandom_range(0, 3) != 0)});
			if ($urandom_range(0, 7) == 0)
				write_reg(CFG_IDX_W'($urandom_range(2, 15)), CFG_DATA_W'($urandom));

			n = 0;
			target = $urandom_range(40, 55);
			while (n < target) begin
				case ($urandom_range(0, 15))
					0, 1, 2, 3, 4, 5, 6, 7: begin
						// literal run, sometimes the longest, sometimes cut short
						if ($urandom_range(0, 31) == 0)
							len = 128;
						else if ($urandom_range(0, 7) == 0)
							len = $urandom_range(1, 128);
						else
							len = $urandom_range(1, 6);
						keep = ($urandom_range(0, 7) == 0) ? $urandom_range(0, len - 1) : len;
						push_byte(8'(len - 1), 1'b0, '0);
						repeat (keep) push_byte(8'($urandom), 1'b0, '0);
						n += keep + 1;
					end
					8, 9, 10, 11, 12: begin
						// repeat run, header 257 - count
						push_byte(8'(257 - $urandom_range(2, 128)), 1'b0, '0);
						push_byte(8'($urandom), 1'b0, '0);
						n += 2;
					end
					13: begin
						push_byte(HDR_NOOP, 1'b0, '0);
						n++;
					end
					default: begin
						// noise byte wherever it lands
						push_byte(8'($urandom), 1'b0, '0);
						n++;
					end
				endcase
			end
			// often leave a run open across the register change
			if ($urandom_range(0, 1) == 0)
				push_byte(8'($urandom), 1'b0, '0);
		end

		// drain and give trailing headers time to pass
		settle();
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// hard limit on the run
	initial begin
		#400000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/pbd_pkg.sv
rtl/pbd_in_if.sv
rtl/pbd_out_if.sv
rtl/pbd_cfg_if.sv
rtl/pbd_front.sv
rtl/pbd_queue.sv
rtl/pbd_back.sv
rtl/packbits_line_decoder_top.sv
bench/testbench.sv
